// File: hw/rtl/acpu_pkg.sv
// ----------------------------------------------------------------------------
// acpu_pkg
// Shared types and constants of the accumulator execute unit.
// ----------------------------------------------------------------------------
package acpu_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned ADDR_W = 16;
   localparam int unsigned STEP_W = 5;

   // opcodes; 14 and 15 are illegal and have no member
   typedef enum logic [3:0] {
      OP_STOP = 4'd0,
      OP_BRZ  = 4'd1,
      OP_BRN  = 4'd2,
      OP_BRC  = 4'd3,
      OP_BRV  = 4'd4,
      OP_BRA  = 4'd5,
      OP_LDA  = 4'd6,
      OP_STA  = 4'd7,
      OP_ADD  = 4'd8,
      OP_SUB  = 4'd9,
      OP_MUL  = 4'd10,
      OP_DIV  = 4'd11,
      OP_CMP  = 4'd12,
      OP_DSP  = 4'd13
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_MEM_FAULT = 2'd1,
      ST_ILLEGAL   = 2'd2,
      ST_DIV_ZERO  = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_CALC = 1'b1
   } state_type;

   // bit positions in the flag register
   localparam int unsigned FLAG_Z = 0;
   localparam int unsigned FLAG_N = 1;
   localparam int unsigned FLAG_C = 2;
   localparam int unsigned FLAG_V = 3;

   localparam logic [ADDR_W-1:0] PC_STEP = ADDR_W'(3);

   typedef struct packed {
      logic start;
      logic is_div;
   } md_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } md_rsp_type;

endpackage

// File: hw/rtl/acpu_muldiv.sv
// ----------------------------------------------------------------------------
// acpu_muldiv
// Bit-serial multiplier / restoring divider around one shared 34-bit adder.
// ----------------------------------------------------------------------------
module acpu_muldiv (
   input  logic                        clock,
   input  logic                        reset,
   input  acpu_pkg::md_req_type        md_req,
   input  logic [acpu_pkg::DATA_W-1:0] op_a,
   input  logic [acpu_pkg::DATA_W-1:0] op_b,
   output acpu_pkg::md_rsp_type        md_rsp,
   output logic [acpu_pkg::DATA_W-1:0] result
);
   import acpu_pkg::*;

   // r: partial product or remainder; s: multiplicand or quotient/dividend
   // t: multiplier or divisor
   logic [DATA_W-1:0] r_ff, r_in;
   logic [DATA_W-1:0] s_ff, s_in;
   logic [DATA_W-1:0] t_ff, t_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              div_ff, div_in;

   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   add_x;
   logic [DATA_W:0]   add_y;
   logic [DATA_W+1:0] sum;

   assign shifted = {r_ff, s_ff[DATA_W-1]};
   assign add_x   = div_ff ? shifted : {1'b0, r_ff};
   assign add_y   = div_ff ? ~{1'b0, t_ff} : {1'b0, s_ff};
   assign sum     = {1'b0, add_x} + {1'b0, add_y} + (DATA_W+2)'(div_ff);

   always_comb begin
      r_in    = r_ff;
      s_in    = s_ff;
      t_in    = t_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      if (md_req.start) begin
         r_in    = '0;
         s_in    = op_a;
         t_in    = op_b;
         cnt_in  = '0;
         busy_in = 1'b1;
         div_in  = md_req.is_div;
      end else if (busy_ff) begin
         if (div_ff) begin
            // top carry set means the trial subtraction did not borrow
            r_in = sum[DATA_W+1] ? sum[DATA_W-1:0] : shifted[DATA_W-1:0];
            s_in = {s_ff[DATA_W-2:0], sum[DATA_W+1]};
         end else begin
            if (t_ff[0]) begin
               r_in = sum[DATA_W-1:0];
            end
            s_in = {s_ff[DATA_W-2:0], 1'b0};
            t_in = {1'b0, t_ff[DATA_W-1:1]};
         end
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      r_ff   <= r_in;
      s_ff   <= s_in;
      t_ff   <= t_in;
      cnt_ff <= cnt_in;
      div_ff <= div_in;
   end

   assign md_rsp.busy = busy_ff;
   assign md_rsp.done = done_ff;
   assign result      = div_ff ? s_ff : r_ff;

endmodule

// File: hw/rtl/accumulator_cpu_execute.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_execute
// Execute unit of an accumulator machine with a four-bit opcode.
// ----------------------------------------------------------------------------
// One instruction item in, one result item out. Most instructions finish in
// the cycle they are accepted and their result is offered on the next cycle,
// so they run at one item per cycle while results are taken. mul and div go
// through a bit-serial multiply/divide unit that handles one operand bit per
// cycle: such an item is accepted, the unit takes 32 steps, and its done
// strobe then writes the result back into the result registers that offer it.
// If that result is taken at once, the next item can be accepted in the
// same cycle. The block takes no new item meanwhile.
// pc_out, acc_out and the flags show the architectural registers directly.
module accumulator_cpu_execute #(
   parameter int unsigned MEM_BYTES = 65536
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [3:0]                  req_mode,
   input  logic                        req_immediate,
   input  logic [acpu_pkg::ADDR_W-1:0] req_operand,
   input  logic [acpu_pkg::DATA_W-1:0] req_mem_data,
   input  logic                        req_mem_ok,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [acpu_pkg::ADDR_W-1:0] rsp_pc_out,
   output logic [acpu_pkg::DATA_W-1:0] rsp_acc_out,
   output logic                        rsp_flag_z,
   output logic                        rsp_flag_n,
   output logic                        rsp_flag_c,
   output logic                        rsp_flag_v,
   output logic                        rsp_write_en,
   output logic [acpu_pkg::ADDR_W-1:0] rsp_write_addr,
   output logic [acpu_pkg::DATA_W-1:0] rsp_write_data,
   output logic                        rsp_show_en,
   output logic [acpu_pkg::DATA_W-1:0] rsp_show_value
);
   import acpu_pkg::*;

   localparam logic [ADDR_W-1:0] STOP_PC = ADDR_W'((MEM_BYTES / 2) % 65536);

   state_type         state_ff, state_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [ADDR_W-1:0] pc_ff, pc_in;
   logic [3:0]        flags_ff, flags_in;
   logic              pend_div_ff, pend_div_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic              wen_ff, wen_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;
   logic [DATA_W-1:0] wdata_ff, wdata_in;
   logic              sen_ff, sen_in;
   logic [DATA_W-1:0] sval_ff, sval_in;

   md_req_type        md_req;
   md_rsp_type        md_rsp;
   logic [DATA_W-1:0] md_result;

   op_type            op;
   logic              accept;
   logic              illegal;
   logic              uses_mem;
   logic              take;
   logic [DATA_W-1:0] value;
   logic [DATA_W-1:0] add_sum;
   logic [ADDR_W-1:0] pc_next;
   logic [ADDR_W-1:0] target;
   logic              acc_eq;
   logic              acc_lt;

   assign op       = op_type'(req_mode);
   // the two codes above dsp have no instruction
   assign illegal  = (req_mode > OP_DSP);
   assign value    = req_immediate ? DATA_W'(req_operand) : req_mem_data;
   assign uses_mem = (req_mode >= OP_LDA) && (req_mode <= OP_DSP)
                     && ((req_mode == OP_STA) || !req_immediate);
   assign add_sum  = acc_ff + value;
   assign pc_next  = pc_ff + PC_STEP;
   assign target   = req_operand + {req_operand[ADDR_W-2:0], 1'b0};
   assign acc_eq   = (acc_ff == value);
   assign acc_lt   = (acc_ff < value);

   assign req_stall = !((state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      take = 1'b1;
      case (op)
         OP_BRZ:  take = flags_ff[FLAG_Z];
         OP_BRN:  take = flags_ff[FLAG_N];
         OP_BRC:  take = flags_ff[FLAG_C];
         OP_BRV:  take = flags_ff[FLAG_V];
         default: take = 1'b1;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      pc_in        = pc_ff;
      flags_in     = flags_ff;
      pend_div_in  = pend_div_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      wen_in       = wen_ff;
      waddr_in     = waddr_ff;
      wdata_in     = wdata_ff;
      sen_in       = sen_ff;
      sval_in      = sval_ff;
      md_req       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               wen_in       = 1'b0;
               waddr_in     = '0;
               wdata_in     = '0;
               sen_in       = 1'b0;
               sval_in      = '0;
               if (illegal) begin
                  status_in = ST_ILLEGAL;
               end else if (uses_mem && !req_mem_ok) begin
                  status_in = ST_MEM_FAULT;
               end else begin
                  case (op) inside
                     OP_STOP: pc_in = STOP_PC;
                     OP_BRZ, OP_BRN, OP_BRC, OP_BRV, OP_BRA: begin
                        pc_in = take ? target : pc_next;
                     end
                     OP_LDA: begin
                        acc_in = value;
                        pc_in  = pc_next;
                     end
                     OP_STA: begin
                        wen_in   = 1'b1;
                        waddr_in = req_operand;
                        wdata_in = acc_ff;
                        pc_in    = pc_next;
                     end
                     OP_ADD: begin
                        acc_in   = {16'b0, add_sum[15:0]};
                        flags_in = '0;
                        flags_in[FLAG_C] = |add_sum[15:8];
                        pc_in    = pc_next;
                     end
                     OP_SUB, OP_CMP: begin
                        flags_in = '0;
                        flags_in[FLAG_Z] = acc_eq;
                        flags_in[FLAG_N] = acc_lt;
                        if (op == OP_SUB) begin
                           acc_in = acc_ff - value;
                        end
                        pc_in = pc_next;
                     end
                     OP_MUL, OP_DIV: begin
                        if ((op == OP_DIV) && (value == '0)) begin
                           status_in = ST_DIV_ZERO;
                        end else begin
                           // result is offered once the shared unit is done
                           rsp_valid_in  = 1'b0;
                           md_req.start  = 1'b1;
                           md_req.is_div = (op == OP_DIV);
                           pend_div_in   = (op == OP_DIV);
                           state_in      = S_CALC;
                        end
                     end
                     OP_DSP: begin
                        sen_in  = 1'b1;
                        sval_in = value;
                        pc_in   = pc_next;
                     end
                     default: ;
                  endcase
               end
            end
         end
         S_CALC: begin
            if (md_rsp.done) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               wen_in       = 1'b0;
               waddr_in     = '0;
               wdata_in     = '0;
               sen_in       = 1'b0;
               sval_in      = '0;
               pc_in        = pc_next;
               flags_in     = '0;
               if (pend_div_ff) begin
                  acc_in           = {16'b0, md_result[15:0]};
                  flags_in[FLAG_V] = |md_result[15:8];
               end else begin
                  acc_in           = md_result;
                  flags_in[FLAG_V] = |md_result[DATA_W-1:8];
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         pc_ff        <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pc_ff        <= pc_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_div_ff <= pend_div_in;
      status_ff   <= status_in;
      wen_ff      <= wen_in;
      waddr_ff    <= waddr_in;
      wdata_ff    <= wdata_in;
      sen_ff      <= sen_in;
      sval_ff     <= sval_in;
   end

   acpu_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .op_a   (acc_ff),
      .op_b   (value),
      .md_rsp (md_rsp),
      .result (md_result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_pc_out     = pc_ff;
   assign rsp_acc_out    = acc_ff;
   assign rsp_flag_z     = flags_ff[FLAG_Z];
   assign rsp_flag_n     = flags_ff[FLAG_N];
   assign rsp_flag_c     = flags_ff[FLAG_C];
   assign rsp_flag_v     = flags_ff[FLAG_V];
   assign rsp_write_en   = wen_ff;
   assign rsp_write_addr = waddr_ff;
   assign rsp_write_data = wdata_ff;
   assign rsp_show_en    = sen_ff;
   assign rsp_show_value = sval_ff;

   // no new item while the shared unit works
   a_no_accept_in_calc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CALC) |-> req_stall)
      else $error("item accepted during mul/div");

   a_done_only_in_calc: assert property (@(posedge clock) disable iff (reset)
      md_rsp.done |-> (state_ff == S_CALC))
      else $error("mul/div done outside calc state");

   a_unit_busy_in_calc: assert property (@(posedge clock) disable iff (reset)
      md_rsp.busy |-> (state_ff == S_CALC) && !rsp_valid_ff)
      else $error("mul/div busy while idle or result pending");

   a_error_no_side_effect: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != ST_OK)) |-> (!wen_ff && !sen_ff))
      else $error("failed item writes or shows");

endmodule
